>>> rtl/core/spb_pkg.sv
// Package for the spatial point bucket: payload structs, codes and sizes.
// No dependencies; used by every module in rtl/core.
package spb_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = 6;
    localparam int IDX_W    = 5;
    localparam int COORD_W  = 24;
    localparam int DATA_W   = 32;
    localparam int DIST_W   = 52;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_POINT   = 2'd0,
        KIND_STATUS  = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    localparam logic [1:0] ADDR_MIN_DIST = 2'd0;
    localparam logic [1:0] ADDR_MAX_RET  = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [DATA_W-1:0]  v;
        logic signed [DATA_W-1:0]  s;
    } point_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [DATA_W-1:0]  sample_value;
        logic signed [DATA_W-1:0]  smoothing;
        logic signed [COORD_W-1:0] box_xmin;
        logic signed [COORD_W-1:0] box_xmax;
        logic signed [COORD_W-1:0] box_ymin;
        logic signed [COORD_W-1:0] box_ymax;
        logic signed [COORD_W-1:0] box_zmin;
        logic signed [COORD_W-1:0] box_zmax;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                result_kind;
        logic                      accepted;
        logic                      bucket_full;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic signed [DATA_W-1:0]  out_value;
        logic signed [DATA_W-1:0]  out_smoothing;
        logic [CNT_W-1:0]          match_count;
        logic                      overflow;
        logic                      is_last;
    } out_item_t;

    // What one cell reports about the point passing through it.
    typedef struct packed {
        logic valid;
        logic dup;
        logic in_box;
    } cell_flags_t;

endpackage

>>> rtl/core/spb_cell.sv
// One cell of the point chain: holds one stored point and compares it
// against the probe point or query box. Uses spb_pkg.
module spb_cell
    import spb_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  point_t                    load_point,
    input  logic                      shift,
    input  point_t                    prev_point,
    input  logic                      prev_valid,
    input  in_item_t                  probe,
    input  logic [DIST_W-1:0]         min_dist_sq,
    output point_t                    point,
    output logic                      valid,
    output cell_flags_t               flags
);

    point_t             point_reg;
    logic               valid_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               box_reg;
    logic signed [COORD_W:0] dx, dy, dz;
    logic [COORD_W-1:0] ax, ay, az;
    logic [2*COORD_W-1:0] sx, sy, sz;
    logic [DIST_W-1:0]  dist_next;

    // Rotation: during a scan each point walks from one cell to the next on
    // every shift, so the head cell sees every stored point in store order.
    always_ff @(posedge aclk) begin
        if (load) begin
            point_reg <= load_point;
        end else if (shift) begin
            point_reg <= prev_point;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (shift) begin
            valid_reg <= prev_valid;
        end
    end

    always_comb begin
        dx = {point_reg.x[COORD_W-1], point_reg.x} - {probe.pos_x[COORD_W-1], probe.pos_x};
        dy = {point_reg.y[COORD_W-1], point_reg.y} - {probe.pos_y[COORD_W-1], probe.pos_y};
        dz = {point_reg.z[COORD_W-1], point_reg.z} - {probe.pos_z[COORD_W-1], probe.pos_z};
        ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        az = dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
        sx = ax * ax;
        sy = ay * ay;
        sz = az * az;
        dist_next = DIST_W'(sx) + DIST_W'(sy) + DIST_W'(sz);
    end

    // Products registered before the compare.
    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        box_reg  <= point_reg.x >= probe.box_xmin && point_reg.x <= probe.box_xmax &&
                    point_reg.y >= probe.box_ymin && point_reg.y <= probe.box_ymax &&
                    point_reg.z >= probe.box_zmin && point_reg.z <= probe.box_zmax;
    end

    assign point        = point_reg;
    assign valid        = valid_reg;
    assign flags.valid  = valid_reg;
    assign flags.dup    = dist_reg <= min_dist_sq;
    assign flags.in_box = box_reg;

endmodule

>>> rtl/core/spb_chain.sv
// Ring of CAPACITY point cells; appends at a given slot and rotates on
// request. Uses spb_pkg and spb_cell.
module spb_chain
    import spb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  logic               append,
    input  logic [IDX_W-1:0]   append_idx,
    input  point_t             append_point,
    input  logic               shift,
    input  in_item_t           probe,
    input  logic [DIST_W-1:0]  min_dist_sq,
    output point_t             head_point,
    output cell_flags_t        head_flags
);

    point_t      pts   [CAPACITY];
    logic        vld   [CAPACITY];
    cell_flags_t flg   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam int PREV = (i + 1) % CAPACITY;
        spb_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn && !clear),
            .load        (append && append_idx == IDX_W'(i)),
            .load_point  (append_point),
            .shift       (shift),
            .prev_point  (pts[PREV]),
            .prev_valid  (vld[PREV]),
            .probe       (probe),
            .min_dist_sq (min_dist_sq),
            .point       (pts[i]),
            .valid       (vld[i]),
            .flags       (flg[i])
        );
    end

    assign head_point = pts[0];
    assign head_flags = flg[0];

endmodule

>>> rtl/core/spatial_point_bucket.sv
// Top level of the spatial point bucket: APB registers, scan sequencer,
// output register. Depends on spb_pkg and spb_chain.
//
// The bucket keeps up to CAPACITY (32) points in a ring of cells. Inserts
// and box queries walk the ring: the stored points rotate one cell per
// step past the head cell, which compares each against the new point's
// squared distance or the query box. A full rotation takes CAPACITY
// steps, each a distance product (ST_CALC) then a compare (ST_EVAL); a
// step stalls while a point result waits for the output channel. A clear
// skips the scan. A query emits matching points in store order, then one
// summary transaction. The ring always returns to its original order, so
// store order is kept. Registers: min_dist_sq at 0x0 (52 bits),
// max_returned at 0x8 (6 bits, reset 32); pready is tied high.
// Configuration may only change while the bucket is idle.
module spatial_point_bucket
    import spb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_EVAL = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    in_item_t           item_reg;
    logic [DIST_W-1:0]  min_dist_reg;
    logic [CNT_W-1:0]   max_ret_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   nmatch_reg;
    logic               ovf_reg;
    logic               dup_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;
    point_t             head_point;
    cell_flags_t        head_flags;
    logic               shift, append, clear_ring, out_free, cfg_wr;
    logic [1:0]         cfg_idx;
    logic               scan_end, is_query, emit_pt, limit_hit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2] >> 1;
    assign prdata  = (cfg_idx == ADDR_MIN_DIST) ? 64'(min_dist_reg)
                   : (cfg_idx == ADDR_MAX_RET)  ? 64'(max_ret_reg) : 64'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_dist_reg <= '0;
            max_ret_reg  <= CNT_W'(32);
        end else if (cfg_wr) begin
            if (cfg_idx == ADDR_MIN_DIST && paddr[2] == 1'b0) begin
                min_dist_reg <= pwdata[DIST_W-1:0];
            end
            if (cfg_idx == ADDR_MAX_RET && paddr[2] == 1'b0) begin
                max_ret_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == ST_IDLE;

    // One evaluation per step; a query point result needs the output free.
    assign is_query  = item_reg.operation == OP_QUERY;
    assign scan_end  = step_reg == CNT_W'(CAPACITY);
    assign limit_hit = is_query && head_flags.valid && nmatch_reg >= max_ret_reg;
    assign emit_pt   = is_query && head_flags.valid && !limit_hit && !ovf_reg
                       && head_flags.in_box;
    assign shift     = state_reg == ST_EVAL && (!emit_pt || out_free);
    assign append    = state_reg == ST_DONE && out_free && item_reg.operation == OP_INSERT
                       && !dup_reg && count_reg < CNT_W'(CAPACITY);
    assign clear_ring = state_reg == ST_DONE && out_free && item_reg.operation == OP_CLEAR;

    spb_chain u_chain (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (clear_ring),
        .append       (append),
        .append_idx   (count_reg[IDX_W-1:0]),
        .append_point ({item_reg.pos_x, item_reg.pos_y, item_reg.pos_z,
                        item_reg.sample_value, item_reg.smoothing}),
        .shift        (shift),
        .probe        (item_reg),
        .min_dist_sq  (min_dist_reg),
        .head_point   (head_point),
        .head_flags   (head_flags)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) begin
                state_next = (s_data.operation == OP_INSERT || s_data.operation == OP_QUERY)
                           ? ST_CALC : ST_DONE;
            end
            ST_CALC: state_next = scan_end ? ST_DONE : ST_EVAL;
            ST_EVAL: if (shift) begin
                state_next = ST_CALC;
            end
            ST_DONE: if (out_free) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The output register takes a matching point during a scan, or the closing
    // status or summary transaction; otherwise it holds until accepted.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (state_reg == ST_EVAL && emit_pt && out_free) begin
            m_valid_next              = 1'b1;
            m_data_next               = '0;
            m_data_next.result_kind   = KIND_POINT;
            m_data_next.bucket_full   = count_reg >= CNT_W'(CAPACITY);
            m_data_next.out_x         = head_point.x;
            m_data_next.out_y         = head_point.y;
            m_data_next.out_z         = head_point.z;
            m_data_next.out_value     = head_point.v;
            m_data_next.out_smoothing = head_point.s;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_next             = 1'b1;
            m_data_next              = '0;
            m_data_next.is_last      = 1'b1;
            m_data_next.accepted     = append;
            m_data_next.result_kind  = is_query ? KIND_SUMMARY : KIND_STATUS;
            m_data_next.match_count  = is_query ? nmatch_reg : '0;
            m_data_next.overflow     = is_query && ovf_reg;
            m_data_next.bucket_full  = clear_ring ? 1'b0
                                     : (count_reg + CNT_W'(append)) >= CNT_W'(CAPACITY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (append) begin
                count_reg <= count_reg + 1'b1;
            end else if (clear_ring) begin
                count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            item_reg   <= s_data;
            step_reg   <= '0;
            nmatch_reg <= '0;
            ovf_reg    <= 1'b0;
            dup_reg    <= 1'b0;
        end
        if (shift) begin
            step_reg <= step_reg + 1'b1;
            if (item_reg.operation == OP_INSERT && head_flags.valid && head_flags.dup) begin
                dup_reg <= 1'b1;
            end
            if (limit_hit) begin
                ovf_reg <= 1'b1;
            end
            if (emit_pt) begin
                nmatch_reg <= nmatch_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY)) else $error("stored count above capacity");
    a_no_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |=> !shift) else $error("ring rotated while idle");
    a_match_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        nmatch_reg <= max_ret_reg || state_reg == ST_IDLE) else $error("match limit exceeded");
    a_append_once: assert property (@(posedge aclk) disable iff (!aresetn)
        append |=> !append) else $error("double append");

endmodule
